// ----- src/relay_command_to_modbus_coil_frame_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the relay command to coil frame block
// Concurrent checks clocked on a named clock with an active low reset.
// ----------------------------------------------------------------------------
`ifndef RELAY_COMMAND_TO_MODBUS_COIL_FRAME_MACROS_SVH
`define RELAY_COMMAND_TO_MODBUS_COIL_FRAME_MACROS_SVH

// Generic check: label, clock, active low reset, property, message
`define RCMF_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on the block clock and reset
`define RCMF_ASSERT(lbl, prop, msg) \
  `RCMF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- src/rcmf_pkg.sv -----
// ----------------------------------------------------------------------------
// rcmf_pkg
// Shared types, constants and CRC helpers for the coil frame block.
// ----------------------------------------------------------------------------
package rcmf_pkg;

  // Device table geometry
  localparam int NUM_REGS      = 6;
  localparam int TABLE_ENTRIES = 6;
  localparam int SEARCH_N      = (TABLE_ENTRIES < NUM_REGS) ? TABLE_ENTRIES : NUM_REGS;
  localparam int ENTRY_W       = 39;
  localparam int CFG_IDX_W     = $clog2(NUM_REGS);

  // Table word field positions
  localparam int E_VALID_BIT = 38;

  localparam logic [ENTRY_W-1:0] ENTRY_RESET [NUM_REGS] = '{
    39'd292074618880, 39'd292091396097, 39'd292108173314,
    39'd309254488067, 39'd309271265284, 39'd309288042501
  };

  // Frame and reply constants
  localparam logic [7:0]  FUNC_WRITE_COIL = 8'h05;
  localparam logic [15:0] COIL_ON         = 16'hFF00;
  localparam logic [15:0] COIL_OFF        = 16'h0000;
  localparam logic [15:0] REPLY_BAD_TYPE  = 16'd9000;
  localparam logic [15:0] REPLY_BAD_STATE = 16'd8000;
  localparam logic [2:0]  TYPE_FIRST      = 3'd1;
  localparam logic [2:0]  TYPE_LAST       = 3'd2;

  // Decoded command fields
  typedef struct packed {
    logic [15:0] word;
    logic [2:0]  kind;
    logic [9:0]  id;
    logic [3:0]  st;
    logic        bad_type;
    logic        bad_state;
  } cmd_fields_t;

  // Table lookup result
  typedef struct packed {
    logic        hit;
    logic [7:0]  slave;
    logic [15:0] coil;
  } match_t;

  // One result transaction
  typedef struct packed {
    logic [15:0] reply;
    logic        sent;
    logic [7:0]  slave;
    logic [15:0] coil_index;
    logic [15:0] coil_value;
    logic [15:0] crc;
  } result_t;

  // Modbus CRC-16 over six frame bytes, byte 0 first (elaboration use)
  function automatic logic [15:0] crc16_frame(input logic [5:0][7:0] frame);
    logic [15:0] crc;
    crc = 16'hFFFF;
    for (int i = 0; i < 6; i++) begin
      crc = crc ^ {8'h00, frame[i]};
      for (int b = 0; b < 8; b++) begin
        if (crc[0]) crc = (crc >> 1) ^ 16'hA001;
        else        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // Frame template: slave and coil zero, given coil value
  function automatic logic [5:0][7:0] frame_base(input logic [15:0] value);
    logic [5:0][7:0] frame;
    frame    = '0;
    frame[1] = FUNC_WRITE_COIL;
    frame[4] = value[15:8];
    frame[5] = value[7:0];
    return frame;
  endfunction

  // CRC contribution of each variable bit: slave, coil high, coil low
  function automatic logic [23:0][15:0] crc_columns();
    logic [23:0][15:0] cols;
    logic [5:0][7:0]   frame;
    logic [15:0]       ref_crc;
    int                pos;
    ref_crc = crc16_frame(frame_base(COIL_OFF));
    for (int j = 0; j < 24; j++) begin
      pos   = (j < 8) ? 0 : ((j < 16) ? 2 : 3);
      frame = frame_base(COIL_OFF);
      frame[pos][j % 8] = 1'b1;
      cols[j] = crc16_frame(frame) ^ ref_crc;
    end
    return cols;
  endfunction

  localparam logic [23:0][15:0] CRC_COLS     = crc_columns();
  localparam logic [15:0]       CRC_BASE_ON  = crc16_frame(frame_base(COIL_ON));
  localparam logic [15:0]       CRC_BASE_OFF = crc16_frame(frame_base(COIL_OFF));

endpackage

// ----- src/rcmf_cmd_decode.sv -----
// ----------------------------------------------------------------------------
// rcmf_cmd_decode
// Split a decimal command word into type, three-digit id and state digit.
// ----------------------------------------------------------------------------
module rcmf_cmd_decode
  import rcmf_pkg::*;
(
  input  logic [15:0]  word_i,
  output cmd_fields_t  cmd_o
);

  logic [2:0]  kind;
  logic [31:0] prod;
  logic [12:0] tens;
  logic [15:0] rem;
  logic [12:0] id_full;

  // Leading digit by threshold compare
  always_comb begin
    if      (word_i >= 16'd60000) kind = 3'd6;
    else if (word_i >= 16'd50000) kind = 3'd5;
    else if (word_i >= 16'd40000) kind = 3'd4;
    else if (word_i >= 16'd30000) kind = 3'd3;
    else if (word_i >= 16'd20000) kind = 3'd2;
    else if (word_i >= 16'd10000) kind = 3'd1;
    else                          kind = 3'd0;
  end

  // Divide by ten through the reciprocal, exact over 16 bits
  assign prod    = {16'h0000, word_i} * 32'd52429;
  assign tens    = prod[31:19];
  assign rem     = word_i - ({tens, 3'b000} + {2'b00, tens, 1'b0});
  assign id_full = tens - (13'(kind) * 13'd1000);

  // Pack decoded fields and error flags
  always_comb begin
    cmd_o.word      = word_i;
    cmd_o.kind      = kind;
    cmd_o.id        = id_full[9:0];
    cmd_o.st        = rem[3:0];
    cmd_o.bad_type  = (kind < TYPE_FIRST) || (kind > TYPE_LAST);
    cmd_o.bad_state = (rem[3:0] > 4'd1);
  end

endmodule

// ----- src/rcmf_dev_table.sv -----
// ----------------------------------------------------------------------------
// rcmf_dev_table
// Device table registers with write port and first-match lookup.
// ----------------------------------------------------------------------------
module rcmf_dev_table
  import rcmf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ENTRY_W-1:0]   cfg_wdata_i,
  input  logic [2:0]           kind_i,
  input  logic [9:0]           id_i,
  output match_t               match_o
);

  logic [ENTRY_W-1:0] entry_q [NUM_REGS];

  // Write table words; indexes past the table are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) entry_q[i] <= ENTRY_RESET[i];
    end else if (cfg_we_i) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (cfg_idx_i == CFG_IDX_W'(i)) entry_q[i] <= cfg_wdata_i;
      end
    end
  end

  // Lowest matching valid entry wins
  always_comb begin
    match_o = '0;
    for (int i = SEARCH_N - 1; i >= 0; i--) begin
      if (entry_q[i][E_VALID_BIT] &&
          (entry_q[i][37:34] == {1'b0, kind_i}) &&
          (entry_q[i][33:24] == id_i)) begin
        match_o.hit   = 1'b1;
        match_o.slave = entry_q[i][23:16];
        match_o.coil  = entry_q[i][15:0];
      end
    end
  end

endmodule

// ----- src/rcmf_frame_gen.sv -----
// ----------------------------------------------------------------------------
// rcmf_frame_gen
// Build the write-single-coil frame fields, its CRC and the reply word.
// ----------------------------------------------------------------------------
module rcmf_frame_gen
  import rcmf_pkg::*;
(
  input  cmd_fields_t cmd_i,
  input  match_t      match_i,
  output result_t     res_o
);

  logic        send;
  logic        coil_on;
  logic [23:0] crc_bits;
  logic [15:0] crc;
  logic [15:0] reply_base;
  logic [15:0] reply_add;

  assign send     = !cmd_i.bad_type && !cmd_i.bad_state && match_i.hit;
  assign coil_on  = cmd_i.st[0];
  assign crc_bits = {match_i.coil[7:0], match_i.coil[15:8], match_i.slave};

  // CRC as template value plus one column per set bit
  always_comb begin
    crc = coil_on ? CRC_BASE_ON : CRC_BASE_OFF;
    for (int j = 0; j < 24; j++) begin
      if (crc_bits[j]) crc = crc ^ CRC_COLS[j];
    end
  end

  // Select reply offset by error class
  always_comb begin
    reply_base = send ? cmd_i.word : (cmd_i.word ^ 16'h0001);
    if (cmd_i.bad_type)       reply_add = REPLY_BAD_TYPE;
    else if (cmd_i.bad_state) reply_add = REPLY_BAD_STATE;
    else                      reply_add = 16'(cmd_i.kind) * 16'd1000;
  end

  // Zero frame fields when nothing is sent
  always_comb begin
    res_o.reply      = reply_base + reply_add;
    res_o.sent       = send;
    res_o.slave      = send ? match_i.slave : 8'h00;
    res_o.coil_index = send ? match_i.coil : 16'h0000;
    res_o.coil_value = (send && coil_on) ? COIL_ON : COIL_OFF;
    res_o.crc        = send ? crc : 16'h0000;
  end

endmodule

// ----- src/relay_command_to_modbus_coil_frame.sv -----
// ----------------------------------------------------------------------------
// relay_command_to_modbus_coil_frame
// Decimal relay command to Modbus function-05 coil frame, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one command_word_i per
// transaction. Output channel: out_valid_o / out_stall_i carry the reply,
// the sent flag and the frame fields (slave, coil address, coil value, CRC).
// Every command gives exactly one result transaction.
// Path: a taken command passes an input register, then decode, table match
// and CRC logic, then the result register.
// Throughput: one command per cycle unless out_stall_i holds, set by the two-register pipeline.
// While out_stall_i holds, the result register keeps its contents and one
// more command may wait in the input register; in_stall_o rises only when
// both are full.
// Reset loads the six default table entries and empties both registers.
// The table port cfg_we_i / cfg_idx_i / cfg_wdata_i writes one entry per
// cycle; indexes past the table are ignored. Write it only while idle.
// ----------------------------------------------------------------------------
`include "relay_command_to_modbus_coil_frame_macros.svh"

module relay_command_to_modbus_coil_frame
  import rcmf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ENTRY_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [15:0]          command_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [15:0]          reply_o,
  output logic                 sent_o,
  output logic [7:0]           frame_slave_o,
  output logic [15:0]          frame_coil_addr_o,
  output logic [15:0]          frame_coil_value_o,
  output logic [15:0]          frame_crc_o
);

  logic        in_valid_q;
  logic [15:0] word_q;
  logic        out_valid_q;
  result_t     res_q;
  result_t     res_d;
  cmd_fields_t cmd;
  match_t      match;
  logic        out_free;
  logic        advance;
  logic        in_take;

  // Handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) word_q <= command_word_i;
  end

  rcmf_cmd_decode u_decode (
    .word_i (word_q),
    .cmd_o  (cmd)
  );

  rcmf_dev_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (cmd.kind),
    .id_i        (cmd.id),
    .match_o     (match)
  );

  rcmf_frame_gen u_frame (
    .cmd_i   (cmd),
    .match_i (match),
    .res_o   (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_valid_o        = out_valid_q;
  assign reply_o            = res_q.reply;
  assign sent_o             = res_q.sent;
  assign frame_slave_o      = res_q.slave;
  assign frame_coil_addr_o  = res_q.coil_index;
  assign frame_coil_value_o = res_q.coil_value;
  assign frame_crc_o        = res_q.crc;

  // Checks
  `RCMF_ASSERT(a_stall_from_output, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without output back-pressure")
  `RCMF_ASSERT(a_advance_lands, advance |=> out_valid_o, "advanced transaction did not reach the output")
  `RCMF_ASSERT(a_no_frame_zero, (out_valid_o && !sent_o) |-> (frame_slave_o == 8'h00 && frame_coil_addr_o == 16'h0000 && frame_crc_o == 16'h0000 && frame_coil_value_o == COIL_OFF), "frame fields set without a frame")
  `RCMF_ASSERT(a_coil_value_code, (out_valid_o && sent_o) |-> (frame_coil_value_o == COIL_ON || frame_coil_value_o == COIL_OFF), "illegal coil value in frame")

endmodule

// ----- verif/coil_frame_checker.sv -----
// ----------------------------------------------------------------------------
// coil_frame_checker
// Watches the table port and both channels of the coil frame block. It keeps
// its own copy of the device table, predicts the reply and frame of every
// accepted command, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module coil_frame_checker
  import rcmf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ENTRY_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [15:0]          command_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [15:0]          reply_i,
  input  logic                 sent_i,
  input  logic [7:0]           frame_slave_i,
  input  logic [15:0]          frame_coil_addr_i,
  input  logic [15:0]          frame_coil_value_i,
  input  logic [15:0]          frame_crc_i,
  output int                   fails_o,
  output int                   pending_o
);

  // Decimal command layout
  localparam int unsigned TYPE_SCALE      = 10000;
  localparam int unsigned ID_SCALE        = 1000;
  localparam int unsigned DIGIT_SCALE     = 10;
  localparam int unsigned REPLY_TYPE_STEP = 1000;

  // Table word layout below the valid bit
  localparam int TYPE_LSB  = 34;
  localparam int ID_LSB    = 24;
  localparam int SLAVE_LSB = 16;

  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam int          MAX_PRINTED = 60;

  typedef struct packed {
    logic [15:0] cmd;
    result_t     res;
  } coil_expect_t;

  logic [ENTRY_W-1:0] dev_table [NUM_REGS];
  coil_expect_t       coil_q [$];
  coil_expect_t       oldest;
  int                 error_total = 0;

  assign fails_o = error_total;

  // Reflected CRC-16, one bit at a time; byte 0 sits in the top byte
  function automatic logic [15:0] modbus_crc(input logic [47:0] frame_bytes);
    logic [15:0] acc;
    logic [7:0]  octet;
    logic        fb;
    acc = 16'hFFFF;
    for (int n = 5; n >= 0; n--) begin
      octet = frame_bytes[n*8 +: 8];
      for (int k = 0; k < 8; k++) begin
        fb  = acc[0] ^ octet[k];
        acc = acc >> 1;
        if (fb) acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  // Reply and frame for one command against the current table
  function automatic result_t predict_coil_frame(input logic [15:0] word);
    result_t            r;
    int unsigned        kind;
    int unsigned        id;
    int unsigned        st;
    logic [ENTRY_W-1:0] e;
    bit                 found;
    kind  = word / TYPE_SCALE;
    id    = (word / DIGIT_SCALE) % ID_SCALE;
    st    = word % DIGIT_SCALE;
    r     = '0;
    found = 1'b0;
    if (kind < TYPE_FIRST || kind > TYPE_LAST) begin
      r.reply = (word ^ 16'd1) + REPLY_BAD_TYPE;
    end else if (st > 1) begin
      r.reply = (word ^ 16'd1) + REPLY_BAD_STATE;
    end else begin
      // First valid entry in index order wins; slots past the registers are empty
      for (int i = 0; i < TABLE_ENTRIES && !found; i++) begin
        e = (i < NUM_REGS) ? dev_table[i] : '0;
        if (e[E_VALID_BIT] && e[E_VALID_BIT-1:TYPE_LSB] == kind &&
            e[TYPE_LSB-1:ID_LSB] == id) begin
          found        = 1'b1;
          r.sent       = 1'b1;
          r.slave      = e[ID_LSB-1:SLAVE_LSB];
          r.coil_index = e[SLAVE_LSB-1:0];
          r.coil_value = (st == 1) ? COIL_ON : COIL_OFF;
          r.crc        = modbus_crc({r.slave, FUNC_WRITE_COIL, r.coil_index, r.coil_value});
        end
      end
      if (found) r.reply = word + 16'(kind * REPLY_TYPE_STEP);
      else       r.reply = (word ^ 16'd1) + 16'(kind * REPLY_TYPE_STEP);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] cmd,
                                 input logic [15:0] got, input logic [15:0] want);
    if (error_total < MAX_PRINTED)
      $display("[%0t] mismatch, %s: command %0d got 0x%h expected 0x%h",
               $realtime, what, cmd, got, want);
    error_total++;
  endtask

  // Track the table, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) dev_table[i] = ENTRY_RESET[i];
      coil_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < NUM_REGS) dev_table[cfg_idx_i] = cfg_wdata_i;

      if (out_valid_i && !out_stall_i) begin
        if (coil_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 16'h0, reply_i, 16'h0);
        end else begin
          oldest = coil_q.pop_front();
          if (reply_i !== oldest.res.reply)
            report_mismatch("reply", oldest.cmd, reply_i, oldest.res.reply);
          if (sent_i !== oldest.res.sent)
            report_mismatch("sent", oldest.cmd, 16'(sent_i), 16'(oldest.res.sent));
          if (frame_slave_i !== oldest.res.slave)
            report_mismatch("slave", oldest.cmd, 16'(frame_slave_i), 16'(oldest.res.slave));
          if (frame_coil_addr_i !== oldest.res.coil_index)
            report_mismatch("coil address", oldest.cmd, frame_coil_addr_i,
                            oldest.res.coil_index);
          if (frame_coil_value_i !== oldest.res.coil_value)
            report_mismatch("coil value", oldest.cmd, frame_coil_value_i,
                            oldest.res.coil_value);
          if (frame_crc_i !== oldest.res.crc)
            report_mismatch("crc", oldest.cmd, frame_crc_i, oldest.res.crc);
        end
      end

      if (in_valid_i && !in_stall_i)
        coil_q.push_back('{cmd: command_word_i, res: predict_coil_frame(command_word_i)});

      pending_o <= coil_q.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives relay commands and device table writes into the coil frame block.
// Directed commands cover the decode edges and table extremes; random phases
// reload the table and mix hits, misses and bad commands under bursty input
// and a stalling receiver. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb;
  import rcmf_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 3;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int TYPE_WEIGHT  = 10000;
  localparam int ID_WEIGHT    = 10;
  localparam int ID_MAX       = 999;

  localparam int                   IDX_FIRST_ENTRY = 0;
  localparam logic [CFG_IDX_W-1:0] IDX_PAST_TABLE  = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] IDX_TOP         = '1;
  localparam logic [ENTRY_W-1:0]   ENTRY_ALL_ONES  = '1;

  // Edge entries: type 1 id 999 to the top slave and coil, type 2 id 0 to zero
  localparam logic [ENTRY_W-1:0] ENTRY_HIGH_CORNER = {1'b1, 4'd1, 10'd999, 8'hFF, 16'hFFFF};
  localparam logic [ENTRY_W-1:0] ENTRY_LOW_CORNER  = {1'b1, 4'd2, 10'd0, 8'h00, 16'h0000};
  localparam logic [ENTRY_W-1:0] ENTRY_SHADOWED    = {1'b1, 4'd1, 10'd999, 8'h5A, 16'h1234};
  localparam logic [ENTRY_W-1:0] ENTRY_DISABLED    = {1'b0, 4'd2, 10'd7, 8'h11, 16'h2222};

  // Against the default table: type and state edges, hits, misses, wrap
  localparam logic [15:0] RESET_TABLE_CMDS [18] = '{
    16'd0, 16'd9999, 16'd65535, 16'd30000, 16'd10010, 16'd10011,
    16'd10021, 16'd10031, 16'd20010, 16'd20021, 16'd20031, 16'd10012,
    16'd19999, 16'd10041, 16'd20000, 16'd29991, 16'd10001, 16'd10019
  };
  // Against the edge table: first match, shadowed entry, disabled entry
  localparam logic [15:0] EDGE_TABLE_CMDS [6] = '{
    16'd19990, 16'd19991, 16'd20000, 16'd20001, 16'd20070, 16'd10000
  };

  typedef enum int {CMD_HIT, CMD_MISS, CMD_BAD_STATE, CMD_BAD_TYPE, CMD_NOISE} cmd_kind_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [ENTRY_W-1:0]   cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic [15:0]          cmd_word  = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [15:0]          reply;
  logic                 sent;
  logic [7:0]           frame_slave;
  logic [15:0]          frame_coil_addr;
  logic [15:0]          frame_coil_value;
  logic [15:0]          frame_crc;
  int                   fails;
  int                   pending;

  logic [ENTRY_W-1:0] staged [NUM_REGS];
  logic [ENTRY_W-1:0] loaded [NUM_REGS];
  int                 burst_left  = 0;
  bit                 sender_on   = 1'b0;
  bit                 no_gaps     = 1'b0;
  int                 holds_asked = 0;
  int                 quiet_cycles = 0;

  relay_command_to_modbus_coil_frame u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .command_word_i     (cmd_word),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .reply_o            (reply),
    .sent_o             (sent),
    .frame_slave_o      (frame_slave),
    .frame_coil_addr_o  (frame_coil_addr),
    .frame_coil_value_o (frame_coil_value),
    .frame_crc_o        (frame_crc)
  );

  coil_frame_checker u_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .command_word_i     (cmd_word),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .reply_i            (reply),
    .sent_i             (sent),
    .frame_slave_i      (frame_slave),
    .frame_coil_addr_i  (frame_coil_addr),
    .frame_coil_value_i (frame_coil_value),
    .frame_crc_i        (frame_crc),
    .fails_o            (fails),
    .pending_o          (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] compose_cmd(input int kind, input int id, input int st);
    return 16'(kind * TYPE_WEIGHT + id * ID_WEIGHT + st);
  endfunction

  // Mostly well-formed commands aimed at the loaded table, plus bad ones and noise
  function automatic logic [15:0] make_command();
    cmd_kind_e          pick;
    int                 r;
    logic [ENTRY_W-1:0] e;
    r = $urandom_range(0, 99);
    if (r < 55)      pick = CMD_HIT;
    else if (r < 70) pick = CMD_MISS;
    else if (r < 80) pick = CMD_BAD_STATE;
    else if (r < 90) pick = CMD_BAD_TYPE;
    else             pick = CMD_NOISE;
    case (pick)
      CMD_HIT: begin
        e = loaded[$urandom_range(0, NUM_REGS - 1)];
        if (e[37:34] >= TYPE_FIRST && e[37:34] <= TYPE_LAST && e[33:24] <= ID_MAX)
          return compose_cmd(e[37:34], e[33:24], $urandom_range(0, 1));
        return compose_cmd($urandom_range(TYPE_FIRST, TYPE_LAST), $urandom_range(0, ID_MAX),
                           $urandom_range(0, 1));
      end
      CMD_MISS: begin
        return compose_cmd($urandom_range(TYPE_FIRST, TYPE_LAST), $urandom_range(0, 15),
                           $urandom_range(0, 1));
      end
      CMD_BAD_STATE: begin
        return compose_cmd($urandom_range(TYPE_FIRST, TYPE_LAST), $urandom_range(0, ID_MAX),
                           $urandom_range(2, 9));
      end
      CMD_BAD_TYPE: begin
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, TYPE_WEIGHT - 1));
        return 16'($urandom_range(3 * TYPE_WEIGHT, 65535));
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly valid entries of type 1 or 2 with ids from a small pool
  function automatic logic [ENTRY_W-1:0] random_entry();
    logic [3:0] kind;
    logic [9:0] id;
    kind = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(TYPE_FIRST, TYPE_LAST))
                                       : 4'($urandom);
    id   = ($urandom_range(0, 2) != 0) ? 10'($urandom_range(0, 15)) : 10'($urandom);
    return {($urandom_range(0, 7) != 0), kind, id, 8'($urandom), 16'($urandom)};
  endfunction

  // Offer one command, hold it until taken, then maybe end the burst
  task automatic send_command(input logic [15:0] w);
    int gap;
    in_valid  <= 1'b1;
    cmd_word  <= w;
    sender_on = 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if (no_gaps || $urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0)       gap = 20;
      else                                      gap = $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid  <= 1'b0;
        sender_on = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every outstanding result is back
  task automatic wait_drained();
    if (sender_on) begin
      in_valid  <= 1'b0;
      sender_on = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
  endtask

  // Write all staged entries, optionally poke the indexes past the table
  task automatic load_table(input bit poke_past);
    for (int i = IDX_FIRST_ENTRY; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= staged[i];
      @(posedge clk);
      loaded[i] = staged[i];
    end
    if (poke_past) begin
      cfg_idx   <= IDX_PAST_TABLE;
      cfg_wdata <= ENTRY_ALL_ONES;
      @(posedge clk);
      cfg_idx   <= IDX_TOP;
      cfg_wdata <= ~staged[0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver: stall in changing modes, with a long hold when asked
  initial begin : receiver
    stall_mode_e mode;
    int          left;
    int          tick;
    int          holds_done;
    mode       = STALL_NONE;
    left       = 0;
    tick       = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done < holds_asked) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        if (left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          left = $urandom_range(5, 60);
        end
        left--;
        tick++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // Stimulus: directed commands, then random phases, then the verdict
  initial begin : stimulus
    for (int i = 0; i < NUM_REGS; i++) loaded[i] = ENTRY_RESET[i];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(RESET_TABLE_CMDS); i++) send_command(RESET_TABLE_CMDS[i]);

    // Edge table: empty entry, all-ones entry, corners, a shadowed and a disabled one
    wait_drained();
    staged[0] = '0;
    staged[1] = ENTRY_ALL_ONES;
    staged[2] = ENTRY_HIGH_CORNER;
    staged[3] = ENTRY_LOW_CORNER;
    staged[4] = ENTRY_SHADOWED;
    staged[5] = ENTRY_DISABLED;
    load_table(1'b1);
    for (int i = 0; i < $size(EDGE_TABLE_CMDS); i++) send_command(EDGE_TABLE_CMDS[i]);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          for (int i = 0; i < NUM_REGS; i++) staged[i] = ENTRY_RESET[i];
        end
        3: begin
          for (int i = 0; i < 3; i++) staged[i] = ENTRY_ALL_ONES;
          staged[3] = '0;
          staged[4] = ENTRY_HIGH_CORNER;
          staged[5] = random_entry();
        end
        default: begin
          // Phase four copies type and id to the next entry up to force first-match cases
          for (int i = 0; i < NUM_REGS; i++) begin
            staged[i] = random_entry();
            if (p == 4 && i > 0 && $urandom_range(0, 1) == 0)
              staged[i][37:24] = staged[i-1][37:24];
          end
        end
      endcase
      if (p != 6) load_table(p == 3 || p == 7);

      // Phase two: back-to-back offers while the receiver holds off
      no_gaps = (p == 2);
      if (p == 2) holds_asked++;
      for (int n = 0; n < PHASE_ITEMS; n++) send_command(make_command());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/rcmf_pkg.sv
src/rcmf_cmd_decode.sv
src/rcmf_dev_table.sv
src/rcmf_frame_gen.sv
src/relay_command_to_modbus_coil_frame.sv
verif/coil_frame_checker.sv
verif/tb.sv
